// ===== hdl/ndpad_pkg.sv =====
// Shared types, constants and helpers for the N-dimensional pad address generator.
// No dependencies; imported by every module of the block.
package ndpad_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int AXIS_BITS  = 12;
    localparam int NDIM_W     = 3;
    localparam int CFG_W      = 48;
    localparam int POS_W      = 52;
    localparam int SRC_W      = 48;
    localparam int OFF_W      = 52;
    localparam int EB_W       = 5;
    localparam int OLEN_W     = AXIS_BITS + 2;
    localparam int DIV_BPS    = 4;
    localparam int DIV_STAGES = (POS_W + DIV_BPS - 1) / DIV_BPS;
    localparam int DQ_W       = DIV_STAGES * DIV_BPS;
    localparam int CIDX_W     = 3;

    typedef enum logic [CIDX_W-1:0] {
        REG_NUM_DIMS      = 3'd0,
        REG_AXIS_LENGTHS  = 3'd1,
        REG_PAD_BEFORE    = 3'd2,
        REG_PAD_AFTER     = 3'd3,
        REG_EXTEND_EDGES  = 3'd4,
        REG_ELEMENT_BYTES = 3'd5
    } t_reg_idx;

    // One item in flight: remaining position (quotient), partial source index and stride.
    typedef struct packed {
        logic             valid;
        logic [DQ_W-1:0]  dq;
        logic [SRC_W-1:0] src;
        logic [SRC_W-1:0] stride;
        logic             zero;
        logic             err;
    } t_item;

    typedef struct packed {
        t_item             it;
        logic [OLEN_W-1:0] rem;
    } t_div;

    typedef struct packed {
        t_item                it;
        logic [AXIS_BITS-1:0] c;
    } t_adj;

    typedef struct packed {
        logic [AXIS_BITS-1:0] len;
        logic [AXIS_BITS-1:0] bef;
        logic [AXIS_BITS-1:0] aft;
        logic                 active;
        logic                 extend;
    } t_axis_cfg;

    function automatic logic [AXIS_BITS-1:0] axis_field(input logic [CFG_W-1:0] r,
                                                        input int axis);
        logic [CFG_W-1:0] sh;
        sh = r >> (axis * AXIS_BITS);
        return sh[AXIS_BITS-1:0];
    endfunction

    // DIV_BPS restoring division steps, dividend bits taken MSB first.
    function automatic t_div div_step(input t_div x, input logic [OLEN_W-1:0] d);
        t_div          y;
        logic [OLEN_W:0] r2;
        y = x;
        for (int j = 0; j < DIV_BPS; j++) begin
            r2 = {y.rem, y.it.dq[DQ_W-1]};
            y.it.dq = {y.it.dq[DQ_W-2:0], 1'b0};
            if (r2 >= {1'b0, d}) begin
                r2 = r2 - {1'b0, d};
                y.it.dq[0] = 1'b1;
            end
            y.rem = r2[OLEN_W-1:0];
        end
        return y;
    endfunction

endpackage

// ===== hdl/ndpad_axis.sv =====
// One axis of the address pipeline: pipelined division by the padded length,
// padding decision, and source index accumulation. Depends on ndpad_pkg.
module ndpad_axis import ndpad_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_axis_cfg i_cfg,
    input  t_item     i_item,
    output t_item     o_item
);

    logic [AXIS_BITS-1:0] w_len;
    logic [AXIS_BITS-1:0] w_bef;
    logic [OLEN_W-1:0]    w_olen;
    logic [OLEN_W-1:0]    w_upper;
    logic                 w_keep;

    t_div r_div [DIV_STAGES];
    t_div n_div [DIV_STAGES];
    t_adj r_adj, n_adj;
    t_item r_mul, n_mul;

    // Unused axes act as a length-one axis with no padding.
    always_comb begin
        w_len   = i_cfg.active ? i_cfg.len : AXIS_BITS'(1);
        w_bef   = i_cfg.active ? i_cfg.bef : '0;
        w_olen  = i_cfg.active ? (OLEN_W'(i_cfg.len) + OLEN_W'(i_cfg.bef) + OLEN_W'(i_cfg.aft))
                               : OLEN_W'(1);
        w_upper = OLEN_W'(w_bef) + OLEN_W'(w_len);
        w_keep  = i_cfg.extend && (w_len != '0);
    end

    always_comb begin
        t_div first;
        first.it  = i_item;
        first.rem = '0;
        n_div[0]  = div_step(first, w_olen);
        for (int k = 1; k < DIV_STAGES; k++) begin
            n_div[k] = div_step(r_div[k-1], w_olen);
        end
    end

    always_comb begin
        t_div last;
        last     = r_div[DIV_STAGES-1];
        n_adj.it = last.it;
        n_adj.c  = '0;
        if (w_olen == '0) begin
            n_adj.it.err = 1'b1;
        end
        if (last.rem < OLEN_W'(w_bef)) begin
            if (!w_keep) n_adj.it.zero = 1'b1;
        end else if (last.rem >= w_upper) begin
            if (w_keep) n_adj.c = w_len - AXIS_BITS'(1);
            else        n_adj.it.zero = 1'b1;
        end else begin
            n_adj.c = AXIS_BITS'(last.rem - OLEN_W'(w_bef));
        end
    end

    always_comb begin
        n_mul        = r_adj.it;
        n_mul.src    = r_adj.it.src + SRC_W'(r_adj.c * r_adj.it.stride);
        n_mul.stride = SRC_W'(r_adj.it.stride * w_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) r_div[k].it.valid <= 1'b0;
            r_adj.it.valid <= 1'b0;
            r_mul.valid    <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) r_div[k] <= n_div[k];
            r_adj <= n_adj;
            r_mul <= n_mul;
        end
    end

    assign o_item = r_mul;

endmodule

// ===== hdl/nd_pad_source_address_core.sv =====
// Top level of the N-dimensional pad source address generator.
// Depends on ndpad_pkg and ndpad_axis.

// Takes one beat per clock unless o_stall is high, and returns one result beat per
// input beat, in order. Each axis divides the 52-bit position by its padded length
// four quotient bits per stage, then spends one stage on the padding decision and
// one on the stride products; a last stage forms the byte offset and holds the
// result. A stall on the output freezes the whole pipeline and is returned on
// o_stall in the same cycle.
// Configuration takes effect at once and must only be written while idle.
module nd_pad_source_address_core import ndpad_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [POS_W-1:0]   i_out_position,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_fill_zero,
    output logic [SRC_W-1:0]   o_src_element,
    output logic [OFF_W-1:0]   o_src_byte_offset,
    output logic               o_status
);

    logic [NDIM_W-1:0] r_num_dims;
    logic [CFG_W-1:0]  r_axis_len;
    logic [CFG_W-1:0]  r_pad_bef;
    logic [CFG_W-1:0]  r_pad_aft;
    logic              r_extend;
    logic [EB_W-1:0]   r_elem_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims   <= NDIM_W'(1);
            r_axis_len   <= CFG_W'(1);
            r_pad_bef    <= '0;
            r_pad_aft    <= '0;
            r_extend     <= 1'b0;
            r_elem_bytes <= EB_W'(4);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_NUM_DIMS:      r_num_dims   <= i_cfg_wdata[NDIM_W-1:0];
                REG_AXIS_LENGTHS:  r_axis_len   <= i_cfg_wdata;
                REG_PAD_BEFORE:    r_pad_bef    <= i_cfg_wdata;
                REG_PAD_AFTER:     r_pad_aft    <= i_cfg_wdata;
                REG_EXTEND_EDGES:  r_extend     <= i_cfg_wdata[0];
                REG_ELEMENT_BYTES: r_elem_bytes <= i_cfg_wdata[EB_W-1:0];
                default: ;
            endcase
        end
    end

    int    w_dims;
    logic  w_en;
    t_item w_chain [MAX_DIMS+1];

    always_comb begin
        w_dims = int'(r_num_dims);
        if (w_dims < 1) w_dims = 1;
        if (w_dims > MAX_DIMS) w_dims = MAX_DIMS;
    end

    logic r_valid;
    assign w_en    = !(r_valid && i_stall);
    assign o_stall = !w_en;

    always_comb begin
        w_chain[0].valid  = i_valid;
        w_chain[0].dq     = DQ_W'(i_out_position);
        w_chain[0].src    = '0;
        w_chain[0].stride = SRC_W'(1);
        w_chain[0].zero   = 1'b0;
        w_chain[0].err    = 1'b0;
    end

    for (genvar a = 0; a < MAX_DIMS; a++) begin : g_axis
        t_axis_cfg w_cfg;
        always_comb begin
            w_cfg.len    = axis_field(r_axis_len, a);
            w_cfg.bef    = axis_field(r_pad_bef, a);
            w_cfg.aft    = axis_field(r_pad_aft, a);
            w_cfg.active = (a < w_dims);
            w_cfg.extend = r_extend;
        end
        ndpad_axis u_axis (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cfg   (w_cfg),
            .i_item  (w_chain[a]),
            .o_item  (w_chain[a+1])
        );
    end

    t_item            w_last;
    logic             n_fill, n_status;
    logic [SRC_W-1:0] n_src;
    logic [OFF_W-1:0] n_off;
    logic             r_fill, r_status;
    logic [SRC_W-1:0] r_src;
    logic [OFF_W-1:0] r_off;

    // Leftover quotient means the position lies beyond the padded volume.
    always_comb begin
        w_last   = w_chain[MAX_DIMS];
        n_fill   = 1'b0;
        n_status = 1'b0;
        n_src    = '0;
        n_off    = '0;
        if (w_last.err || (w_last.dq != '0)) begin
            n_status = 1'b1;
        end else if (w_last.zero) begin
            n_fill = 1'b1;
        end else begin
            n_src = w_last.src;
            n_off = OFF_W'(w_last.src) * OFF_W'(r_elem_bytes);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid  <= w_last.valid;
            r_fill   <= n_fill;
            r_status <= n_status;
            r_src    <= n_src;
            r_off    <= n_off;
        end
    end

    assign o_valid           = r_valid;
    assign o_fill_zero       = r_fill;
    assign o_status          = r_status;
    assign o_src_element     = r_src;
    assign o_src_byte_offset = r_off;

endmodule

// ===== hdl/ndpad_checker.sv =====
// Port-level checks for nd_pad_source_address_core, bound to the top level.
// Depends on ndpad_pkg.
module ndpad_checker import ndpad_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic [CIDX_W-1:0]  i_cfg_idx,
    input logic [CFG_W-1:0]   i_cfg_wdata,
    input logic               i_valid,
    input logic               o_stall,
    input logic [POS_W-1:0]   i_out_position,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_fill_zero,
    input logic [SRC_W-1:0]   o_src_element,
    input logic [OFF_W-1:0]   o_src_byte_offset,
    input logic               o_status
);

    // Hold a stalled result beat.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_src_element) && $stable(o_status)))
        else $error("stalled result changed");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (!o_fill_zero && o_src_element == '0
                                   && o_src_byte_offset == '0))
        else $error("error beat carries data");

    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fill_zero) |-> (!o_status && o_src_element == '0
                                      && o_src_byte_offset == '0))
        else $error("zero-fill beat carries data");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output backpressure");

endmodule

bind nd_pad_source_address_core ndpad_checker u_ndpad_checker (.*);

// ===== bench/tb_top.sv =====
// Testbench for nd_pad_source_address_core: random and directed padded positions,
// checked against a behavioral address predictor. Depends on ndpad_pkg.
`timescale 1ns / 1ps

module tb_top;
    import ndpad_pkg::*;

    localparam int LATENCY   = 70;
    localparam int WDOG_MAX  = 5000;

    typedef struct {
        logic             fill_zero;
        logic [SRC_W-1:0] src_element;
        logic [OFF_W-1:0] byte_offset;
        logic             status;
    } t_addr;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CIDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_wdata;
    logic               i_valid;
    logic               o_stall;
    logic [POS_W-1:0]   i_out_position;
    logic               o_valid;
    logic               i_stall;
    logic               o_fill_zero;
    logic [SRC_W-1:0]   o_src_element;
    logic [OFF_W-1:0]   o_src_byte_offset;
    logic               o_status;

    nd_pad_source_address_core DUT (.*);

    // Predictor copy of the register file.
    logic [2:0]       cur_dims;
    logic [CFG_W-1:0] cur_len, cur_bef, cur_aft;
    logic             cur_ext;
    logic [EB_W-1:0]  cur_eb;

    logic [POS_W-1:0] pending_pos[$];
    t_addr            expected_addr[$];
    bit               feeding_done;
    bit               hold_sender;
    int               mismatches;
    int               idle_cycles;
    int               send_wait;
    int               recv_wait;

    function automatic t_addr predict_addr(logic [POS_W-1:0] p);
        t_addr r;
        longint unsigned pos, src, stride, len, bef, aft, olen, c;
        int dims;
        bit zero, err;
        pos = p; src = 0; stride = 1; zero = 0; err = 0;
        dims = cur_dims;
        if (dims < 1) dims = 1;
        if (dims > MAX_DIMS) dims = MAX_DIMS;
        for (int a = 0; a < dims; a++) begin
            len = (cur_len >> (a * AXIS_BITS)) & 12'hfff;
            bef = (cur_bef >> (a * AXIS_BITS)) & 12'hfff;
            aft = (cur_aft >> (a * AXIS_BITS)) & 12'hfff;
            olen = len + bef + aft;
            if (olen == 0) begin
                err = 1;
                break;
            end
            c = pos % olen;
            pos = pos / olen;
            if (c < bef) begin
                if (cur_ext && len != 0) c = 0;
                else zero = 1;
            end else if (c >= bef + len) begin
                if (cur_ext && len != 0) c = len - 1;
                else zero = 1;
            end else begin
                c = c - bef;
            end
            src += c * stride;
            stride *= len;
        end
        if (!err && pos != 0) err = 1;
        r = '{1'b0, '0, '0, 1'b0};
        if (err) r.status = 1;
        else if (zero) r.fill_zero = 1;
        else begin
            r.src_element = src[SRC_W-1:0];
            r.byte_offset = (src[SRC_W-1:0] * longint'(cur_eb)) & 64'hf_ffff_ffff_ffff;
        end
        return r;
    endfunction

    // Padded volume under the current settings.
    function automatic longint unsigned volume();
        longint unsigned v;
        int dims;
        v = 1;
        dims = (cur_dims < 1) ? 1 : (cur_dims > MAX_DIMS) ? MAX_DIMS : cur_dims;
        for (int a = 0; a < dims; a++)
            v *= ((cur_len >> (a * AXIS_BITS)) & 12'hfff) + ((cur_bef >> (a * AXIS_BITS))
                 & 12'hfff) + ((cur_aft >> (a * AXIS_BITS)) & 12'hfff);
        return v;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: one beat from the queue after a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            send_wait <= $urandom_range(0, 11);
        end else if (i_valid && !o_stall) begin
            expected_addr.push_back(predict_addr(i_out_position));
            void'(pending_pos.pop_front());
            send_wait = $urandom_range(0, 11);
            if (send_wait == 0 && pending_pos.size() > 0 && !hold_sender) begin
                i_out_position <= pending_pos[0];
            end else begin
                i_valid <= 0;
            end
        end else if (!i_valid && pending_pos.size() > 0 && !hold_sender) begin
            if (send_wait > 0) send_wait <= send_wait - 1;
            else begin
                i_valid <= 1;
                i_out_position <= pending_pos[0];
            end
        end
    end

    // Monitor: random stall per beat, compare against oldest expectation.
    always @(posedge i_clk) begin
        t_addr e;
        if (!i_rst_n) begin
            i_stall <= 0;
            recv_wait <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_addr.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat");
                end else begin
                    e = expected_addr.pop_front();
                    if (e.fill_zero !== o_fill_zero || e.src_element !== o_src_element ||
                        e.byte_offset !== o_src_byte_offset || e.status !== o_status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp z=%0b s=%0h o=%0h st=%0b got z=%0b s=%0h o=%0h st=%0b",
                                e.fill_zero, e.src_element, e.byte_offset, e.status,
                                o_fill_zero, o_src_element, o_src_byte_offset, o_status);
                    end
                end
                recv_wait = $urandom_range(0, 11);
                i_stall <= (recv_wait != 0);
            end else if (i_stall) begin
                if (recv_wait > 1) recv_wait <= recv_wait - 1;
                else i_stall <= 0;
            end
        end
    end

    // Watchdog on cycles without a handshake.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || pending_pos.size() == 0 && expected_addr.size() == 0)
            idle_cycles <= 0;
        else if (idle_cycles >= WDOG_MAX) begin
            $display("nd_pad_source_address_core verification failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_NUM_DIMS:      cur_dims = val[2:0];
            REG_AXIS_LENGTHS:  cur_len = val;
            REG_PAD_BEFORE:    cur_bef = val;
            REG_PAD_AFTER:     cur_aft = val;
            REG_EXTEND_EDGES:  cur_ext = val[0];
            REG_ELEMENT_BYTES: cur_eb = val[EB_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        wait (pending_pos.size() == 0 && expected_addr.size() == 0);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pack4(int lim);
        logic [CFG_W-1:0] v;
        for (int a = 0; a < 4; a++) v[a*AXIS_BITS +: AXIS_BITS] = $urandom_range(0, lim);
        return v;
    endfunction

    // Mostly in-volume positions, a few just beyond and some wild ones.
    task automatic load_random(int n);
        longint unsigned v;
        logic [POS_W-1:0] p;
        v = volume();
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: p = {$urandom, $urandom};
                1: p = (v < 64'h10_0000_0000_0000) ? v + $urandom_range(0, 3) : '1;
                default: p = (v == 0) ? $urandom_range(0, 7)
                           : ({$urandom, $urandom} % v);
            endcase
            pending_pos.push_back(p);
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = REG_NUM_DIMS;
        i_cfg_wdata = '0;
        i_valid = 0;
        i_stall = 0;
        i_out_position = '0;
        hold_sender = 0;
        mismatches = 0;
        cur_dims = 1; cur_len = 1; cur_bef = 0; cur_aft = 0; cur_ext = 0; cur_eb = 4;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: reset settings, then a small 2-D pad in both modes.
        pending_pos.push_back(0);
        pending_pos.push_back(1);
        pending_pos.push_back('1);
        drain();
        write_reg(REG_NUM_DIMS, 2);
        write_reg(REG_AXIS_LENGTHS, {24'd0, 12'd3, 12'd4});
        write_reg(REG_PAD_BEFORE, {24'd0, 12'd1, 12'd2});
        write_reg(REG_PAD_AFTER, {24'd0, 12'd2, 12'd1});
        write_reg(REG_ELEMENT_BYTES, 16);
        for (int k = 0; k < 8; k++) pending_pos.push_back(k * 5);
        pending_pos.push_back(41);
        pending_pos.push_back(42);
        drain();
        write_reg(REG_EXTEND_EDGES, 1);
        for (int k = 0; k < 6; k++) pending_pos.push_back(k * 7);
        drain();
        // Empty input axis in extend mode, then empty padded axis, num_dims 0 and 7.
        write_reg(REG_AXIS_LENGTHS, {24'd0, 12'd3, 12'd0});
        pending_pos.push_back(0);
        pending_pos.push_back(4);
        drain();
        write_reg(REG_PAD_BEFORE, '0);
        write_reg(REG_PAD_AFTER, '0);
        pending_pos.push_back(0);
        drain();
        write_reg(REG_NUM_DIMS, 0);
        write_reg(REG_AXIS_LENGTHS, '1);
        write_reg(REG_PAD_BEFORE, '1);
        write_reg(REG_PAD_AFTER, '1);
        write_reg(REG_ELEMENT_BYTES, 31);
        pending_pos.push_back(4094);
        pending_pos.push_back(12284);
        drain();
        write_reg(REG_NUM_DIMS, 7);
        pending_pos.push_back('1);
        pending_pos.push_back({$urandom, $urandom} % volume());
        drain();

        // Random phases across settings; sender holds until empty midway.
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_NUM_DIMS, $urandom_range(0, 7));
            write_reg(REG_AXIS_LENGTHS, (ph % 4 == 3) ? pack4(4095) : pack4(9));
            write_reg(REG_PAD_BEFORE, (ph % 4 == 3) ? pack4(4095) : pack4(3));
            write_reg(REG_PAD_AFTER, (ph % 4 == 3) ? pack4(4095) : pack4(3));
            write_reg(REG_EXTEND_EDGES, $urandom_range(0, 1));
            write_reg(REG_ELEMENT_BYTES, (ph == 5) ? 0 : $urandom_range(0, 31));
            load_random(50);
            if (ph == 6) begin
                wait (pending_pos.size() < 25);
                hold_sender = 1;
                wait (!i_valid && expected_addr.size() == 0);
                hold_sender = 0;
            end
            drain();
        end

        if (mismatches == 0)
            $display("nd_pad_source_address_core verification clean");
        else
            $display("nd_pad_source_address_core verification failed");
        $finish;
    end
endmodule
